>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define PLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define PLS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/pls_pkg.sv
package pls_pkg;

  localparam int DEPTH = 16;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DW    = 32;
  localparam int POS_W = 8;

  localparam logic [2:0] MODE_INS_FRONT = 3'd0;
  localparam logic [2:0] MODE_INS_END   = 3'd1;
  localparam logic [2:0] MODE_INS_POS   = 3'd2;
  localparam logic [2:0] MODE_DEL_FRONT = 3'd3;
  localparam logic [2:0] MODE_DEL_END   = 3'd4;
  localparam logic [2:0] MODE_DEL_POS   = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_INS  = 2'd1;
  localparam logic [1:0] KIND_DEL  = 2'd2;

  // Write request into the element store.
  typedef struct packed {
    logic          we;
    logic [AW-1:0] addr;
    logic [DW-1:0] data;
  } ram_wr_t;

endpackage

>>> hw/rtl/pls_ram.sv
module pls_ram
  import pls_pkg::*;
(
  input  logic          clk,
  input  pls_pkg::ram_wr_t wr,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // Read-first: a read of the entry being written returns the old word.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/positional_list_store_top.sv
// Ordered list of up to DEPTH signed 32-bit words. Pulse start while busy is
// low to apply one operation (insert or delete at front, end or position).
// The block then streams the whole resulting list on the out_ ports, one word
// per cycle with out_valid high, index 0 first and out_last on the final word;
// an empty list gives one word with out_list_empty set. The receiver cannot
// stall: each word is present for exactly one cycle. Busy stays high from the
// accepting edge until the last word has been shown, so an operation that
// leaves the list empty holds busy for one cycle. The last word sits on the
// ports in the final busy cycle, and the next start is taken at the edge that
// ends the cycle after it. The pace comes from the element store's single
// read port: the shift and the listing are fused into one pass that reads one
// entry and writes back one entry per cycle. No clearing pass follows reset.
module positional_list_store_top
  import pls_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              in_mode,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [DW-1:0]    in_value,
  output logic                    out_valid,
  output logic signed [DW-1:0]    out_element,
  output logic [3:0]              out_element_index,
  output logic                    out_last,
  output logic                    out_list_empty,
  output logic [1:0]              out_status,
  output logic [4:0]              out_entry_count
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  // Control state.
  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rk_r, rk_nxt;
  logic          p_vld_r, p_vld_nxt;

  // Operation and pipeline payload.
  logic [CW-1:0] nnew_r, nnew_nxt;
  logic [AW-1:0] place_r, place_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [DW-1:0] val_r, val_nxt;
  logic [CW-1:0] p_k_r, p_k_nxt;
  logic          p_usev_r, p_usev_nxt;
  logic          p_empty_r, p_empty_nxt;

  logic          accept;
  logic [1:0]    acc_status;
  logic [1:0]    acc_kind;
  logic [AW-1:0] acc_place;
  logic [CW-1:0] acc_nnew;
  logic [POS_W:0] pos_ext, cnt_ext;
  logic [POS_W-1:0] pos_m1;
  logic [CW-1:0] cnt_m1;
  logic          full, empty;

  logic [CW-1:0] place_ext;
  logic [CW-1:0] src;
  logic          src_usev;

  ram_wr_t       ram_wr;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;
  logic [DW-1:0] elem;
  logic [CW+3:0] k_wide;
  logic [CW+4:0] n_wide;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // Decode the operation against the current fill.
  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign pos_ext = {1'b0, in_position};
  assign cnt_ext = (POS_W + 1)'(count_r);
  assign pos_m1  = in_position - POS_W'(1);
  assign cnt_m1  = count_r - CW'(1);

  always_comb begin
    acc_status = ST_OK;
    acc_kind   = KIND_NONE;
    acc_place  = '0;
    case (in_mode)
      MODE_INS_FRONT: begin
        if (full) acc_status = ST_FULL;
        else acc_kind = KIND_INS;
      end
      MODE_INS_END: begin
        if (full) begin
          acc_status = ST_FULL;
        end else begin
          acc_kind  = KIND_INS;
          acc_place = count_r[AW-1:0];
        end
      end
      MODE_INS_POS: begin
        if (full) begin
          acc_status = ST_FULL;
        end else if (pos_ext == '0 || pos_ext > cnt_ext + (POS_W + 1)'(1)) begin
          acc_status = ST_BADPOS;
        end else begin
          acc_kind  = KIND_INS;
          acc_place = pos_m1[AW-1:0];
        end
      end
      MODE_DEL_FRONT: begin
        if (empty) acc_status = ST_EMPTY;
        else acc_kind = KIND_DEL;
      end
      MODE_DEL_END: begin
        if (empty) begin
          acc_status = ST_EMPTY;
        end else begin
          acc_kind  = KIND_DEL;
          acc_place = cnt_m1[AW-1:0];
        end
      end
      MODE_DEL_POS: begin
        if (empty) begin
          acc_status = ST_EMPTY;
        end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
          acc_status = ST_BADPOS;
        end else begin
          acc_kind  = KIND_DEL;
          acc_place = pos_m1[AW-1:0];
        end
      end
      default: begin
        acc_status = ST_OK;
      end
    endcase
  end

  always_comb begin
    case (acc_kind)
      KIND_INS: acc_nnew = count_r + CW'(1);
      KIND_DEL: acc_nnew = cnt_m1;
      default:  acc_nnew = count_r;
    endcase
  end

  // Map output place k to the old entry that supplies it. Insert: entries
  // before the place stay, the place takes the new word, later ones come
  // from one below. Delete: entries at and after the place come from one
  // above. Each write follows its read in the next cycle, so every source is
  // read before its entry is overwritten (same-cycle hits read the old word).
  assign place_ext = CW'(place_r);

  always_comb begin
    src      = rk_r;
    src_usev = 1'b0;
    case (kind_r)
      KIND_INS: begin
        if (rk_r == place_ext) src_usev = 1'b1;
        else if (rk_r > place_ext) src = rk_r - CW'(1);
      end
      KIND_DEL: begin
        if (rk_r >= place_ext) src = rk_r + CW'(1);
      end
      default: begin
        src = rk_r;
      end
    endcase
  end

  assign ram_raddr = src[AW-1:0];

  // Sequencer: issue one read per cycle, emit it the cycle after.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    rk_nxt      = rk_r;
    p_vld_nxt   = 1'b0;
    nnew_nxt    = nnew_r;
    place_nxt   = place_r;
    kind_nxt    = kind_r;
    status_nxt  = status_r;
    val_nxt     = val_r;
    p_k_nxt     = p_k_r;
    p_usev_nxt  = 1'b0;
    p_empty_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          count_nxt  = acc_nnew;
          nnew_nxt   = acc_nnew;
          place_nxt  = acc_place;
          kind_nxt   = acc_kind;
          status_nxt = acc_status;
          val_nxt    = in_value;
          rk_nxt     = '0;
          if (acc_nnew == '0) begin
            // Nothing left: one empty-marker word next cycle.
            p_vld_nxt   = 1'b1;
            p_empty_nxt = 1'b1;
            p_k_nxt     = '0;
            state_nxt   = S_DRAIN;
          end else begin
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        p_vld_nxt  = 1'b1;
        p_k_nxt    = rk_r;
        p_usev_nxt = src_usev;
        rk_nxt     = rk_r + CW'(1);
        if (rk_r == nnew_r - CW'(1)) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        // Last word is on the ports this cycle; drop back to idle.
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      rk_r    <= '0;
      p_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rk_r    <= rk_nxt;
      p_vld_r <= p_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nnew_r    <= nnew_nxt;
    place_r   <= place_nxt;
    kind_r    <= kind_nxt;
    status_r  <= status_nxt;
    val_r     <= val_nxt;
    p_k_r     <= p_k_nxt;
    p_usev_r  <= p_usev_nxt;
    p_empty_r <= p_empty_nxt;
  end

  // Emit stage: the listed word is also written back at its new place.
  assign elem = p_empty_r ? '0 : (p_usev_r ? val_r : ram_rdata);

  assign ram_wr.we   = p_vld_r && !p_empty_r;
  assign ram_wr.addr = p_k_r[AW-1:0];
  assign ram_wr.data = elem;

  pls_ram u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign k_wide = (CW + 4)'(p_k_r);
  assign n_wide = (CW + 5)'(nnew_r);

  assign out_valid         = p_vld_r;
  assign out_element       = elem;
  assign out_element_index = k_wide[3:0];
  assign out_last          = p_empty_r || (p_k_r == nnew_r - CW'(1));
  assign out_list_empty    = p_empty_r;
  assign out_status        = status_r;
  assign out_entry_count   = n_wide[4:0];

`include "assert_macros.svh"

  `PLS_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted operation did not raise busy")
  `PLS_ASSERT(a_last_idle, out_valid && out_last |=> !busy, "block still busy after last word")
  `PLS_ASSERT(a_run_gapless, out_valid && !out_last |=> out_valid, "gap inside a listing run")
  `PLS_ASSERT(a_index_step, out_valid && !out_last |=> out_element_index == $past(out_element_index) + 4'd1, "listing index did not advance by one")
  `PLS_ASSERT_ALWAYS(a_idle_quiet, !rst_n |=> !busy && !out_valid, "busy or strobe right after reset")

endmodule
